// ===== rtl/stp_pkg.sv =====
// Package for the stepper trapezoid profiler: widths, action codes and shared types.
// No dependencies.
package stp_pkg;
  localparam int unsigned PosW      = 32;
  localparam int unsigned FracW     = 8;
  localparam int unsigned IvlW      = 32;
  localparam int unsigned WholeW    = 24;
  localparam int unsigned AccW      = 20;
  localparam int unsigned SpeedW    = 34;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_PRESET = 2'd2
  } action_e;

  localparam logic [CfgIdxW-1:0] REG_MIN_IVL   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_IVL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ACCEL     = 2'd2;

  localparam logic [IvlW-1:0] MIN_IVL_RST   = 32'd256000000;
  localparam logic [IvlW-1:0] FIRST_IVL_RST = 32'd244738048;
  localparam logic [AccW-1:0] ACCEL_RST     = 20'd1;

  // 1e6 * 2^(12+FracW), the dividend of the speed computation.
  localparam logic [63:0] SPEED_NUM = 64'd1000000 << (12 + FracW);
  localparam logic [63:0] SPEED_MAX = (64'd1 << 33) - 64'd1;
  localparam logic [63:0] COUNT_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]      action;
    logic [PosW-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic              step_pulse;
    logic              direction;
    logic [PosW-1:0]   current_position;
    logic [WholeW-1:0] step_interval_us;
    logic              running;
  } out_beat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;
endpackage

// ===== rtl/stp_stream_if.sv =====
// Valid/ready stream interface carrying one payload beat.
// No dependencies; the payload type T is a parameter.
interface stp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stepper_trapezoid_profile.sv =====
// Stepper trapezoid profiler top level: sequencer, profile state and output register.
// Depends on stp_pkg, stp_stream_if and stp_divider.
//
// Usage: items arrive on in_if (action and value); every item yields
// exactly one result beat on out_if, in order. A tick without a step, a move to
// the current goal, a preset or an unknown action passes from S_IDLE through S_OUT
// into the output register, and the sequencer then returns to idle for the next beat.
// A step or a new goal recomputes the profile on the shared divider: stop distance,
// interval update and speed in sequence, one quotient at a time, before S_OUT.
// When the ramp restarts from standstill the interval division is skipped, and when
// the axis comes to rest at the goal only the stop distance is needed.
// One item is processed at a time; in_if.ready is high only while the sequencer idles.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once and
// must be made while the block is idle; the block itself does not enforce this.
// Reset (rst_ni, asynchronous) clears position, goal, ramp counter, interval,
// speed, direction and elapsed time and loads the register defaults.
// If the receiver stalls, the result is held in the output register; the next item
// can still be taken and worked on, but its result waits until the register frees.
module stepper_trapezoid_profile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  stp_stream_if.sink                    in_if,
  stp_stream_if.source                  out_if,
  input  logic                          cfg_we_i,
  input  logic [stp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import stp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_STOP, S_DECIDE, S_IVL, S_SPEED, S_OUT
  } state_e;

  state_e state_q;
  logic [IvlW-1:0]   min_ivl_q, first_ivl_q;
  logic [AccW-1:0]   accel_q;
  logic [PosW-1:0]   pos_q, goal_q;
  logic signed [31:0] ramp_q;
  logic [IvlW-1:0]   ivl_q;
  logic [WholeW-1:0] whole_q;
  logic signed [SpeedW-1:0] speed_q;
  logic              cw_q;
  logic [31:0]       elapsed_q;
  logic              pulse_q;
  logic              out_valid_q;
  out_beat_t         out_q;
  logic [63:0]       sts_q;  // stop distance, saturated
  logic              start_div_q, start_div_d;

  div_req_t    dreq;
  logic        dbusy, dbusy_q;
  logic [63:0] dquot;

  in_beat_t ib;
  logic     acc, div_done, out_free, stop_now;
  logic     start_recalc, step_now;

  // Helpers for the recomputation.
  logic [SpeedW-2:0] spd_mag;
  logic [65:0]       sq;
  logic signed [PosW-1:0] gap;
  logic signed [63:0] gap_w, nd, sts_s;
  logic signed [31:0] ramp_new;
  logic signed [34:0] dd;
  logic [34:0]       ad;
  logic [31:0]       elapsed_inc;
  logic [63:0]       cn_new, ivl_clamped;
  logic [63:0]       spd_sat;

  stp_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .busy_o(dbusy),
    .quot_o(dquot));

  assign ib = in_if.data;
  assign in_if.ready = (state_q == S_IDLE);
  assign acc = in_if.valid && in_if.ready;
  assign div_done = dbusy_q && !dbusy;
  assign out_free = !out_valid_q || out_if.ready;

  assign spd_mag = speed_q[SpeedW-1] ? (SpeedW-1)'(-speed_q) : (SpeedW-1)'(speed_q);
  assign sq      = {33'd0, spd_mag} * {33'd0, spd_mag};
  assign gap     = goal_q - pos_q;
  assign gap_w   = 64'(gap);
  assign nd      = -gap_w;
  assign sts_s   = $signed(sts_q);
  assign stop_now = (gap == '0) && (sts_s <= 64'sd1);
  assign dd      = 35'(ramp_q) * 35'sd4 + 35'sd1;
  assign ad      = dd[34] ? 35'(-dd) : 35'(dd);
  assign elapsed_inc = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;

  always_comb begin
    ramp_new = ramp_q;
    if (gap_w > 0) begin
      if (ramp_q > 0) begin
        if (sts_s >= gap_w || !cw_q) ramp_new = 32'(-sts_s);
      end else if (ramp_q < 0) begin
        if (sts_s < gap_w && cw_q) ramp_new = -ramp_q;
      end
    end else if (gap_w < 0) begin
      if (ramp_q > 0) begin
        if (sts_s >= nd || cw_q) ramp_new = 32'(-sts_s);
      end else if (ramp_q < 0) begin
        if (sts_s < nd && !cw_q) ramp_new = -ramp_q;
      end
    end
  end

  // Interval after the ramp update; dquot holds 2cn/|4n+1| here.
  always_comb begin
    if (dd[34]) begin
      cn_new = {32'd0, ivl_q} + dquot;
      if (cn_new > 64'hFFFF_FFFF) cn_new = 64'hFFFF_FFFF;
    end else begin
      cn_new = {32'd0, ivl_q} - dquot;
    end
    if (cn_new < {32'd0, min_ivl_q}) cn_new = {32'd0, min_ivl_q};
    ivl_clamped = (cn_new == 64'd0) ? 64'd1 : cn_new;
  end

  assign spd_sat = (dquot > SPEED_MAX) ? SPEED_MAX : dquot;

  // The divider latches its operands on the start pulse, so they only need to be
  // right in the first cycle of each waiting state.
  always_comb begin
    dreq = '0;
    dreq.start = start_div_q;
    case (state_q)
      S_STOP: begin
        // Stop distance: floor(m^2 / 2^25) / accel.
        dreq.dividend = {23'd0, sq[65:25]};
        dreq.divisor  = {44'd0, (accel_q == '0) ? 20'd1 : accel_q};
      end
      S_IVL: begin
        dreq.dividend = {31'd0, ivl_q, 1'b0};
        dreq.divisor  = {29'd0, ad};
      end
      S_SPEED: begin
        dreq.dividend = SPEED_NUM;
        dreq.divisor  = {32'd0, ivl_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    start_recalc = 1'b0;
    step_now     = 1'b0;
    if (acc) begin
      case (action_e'(ib.action))
        ACT_TICK: begin
          step_now = (whole_q != '0) && (elapsed_inc >= {8'd0, whole_q});
          start_recalc = step_now;
        end
        ACT_MOVE: start_recalc = (goal_q != ib.value);
        default: ;
      endcase
    end
  end

  always_comb begin
    start_div_d = 1'b0;
    case (state_q)
      S_IDLE:   start_div_d = start_recalc;
      S_DECIDE: start_div_d = !stop_now;
      S_IVL:    start_div_d = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_ivl_q   <= MIN_IVL_RST;
      first_ivl_q <= FIRST_IVL_RST;
      accel_q     <= ACCEL_RST;
      pos_q       <= '0;
      goal_q      <= '0;
      ramp_q      <= '0;
      ivl_q       <= '0;
      whole_q     <= '0;
      speed_q     <= '0;
      cw_q        <= 1'b0;
      elapsed_q   <= '0;
      pulse_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      sts_q       <= '0;
      dbusy_q     <= 1'b0;
      start_div_q <= 1'b0;
    end else begin
      dbusy_q     <= dbusy;
      start_div_q <= start_div_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_IVL:   min_ivl_q   <= cfg_data_i;
          REG_FIRST_IVL: first_ivl_q <= cfg_data_i;
          REG_ACCEL:     accel_q     <= cfg_data_i[AccW-1:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            pulse_q <= step_now;
            case (action_e'(ib.action))
              ACT_TICK: begin
                if (step_now) begin
                  pos_q     <= cw_q ? pos_q + 1'b1 : pos_q - 1'b1;
                  elapsed_q <= '0;
                end else begin
                  elapsed_q <= elapsed_inc;
                end
              end
              ACT_MOVE: if (start_recalc) goal_q <= ib.value;
              ACT_PRESET: begin
                pos_q   <= ib.value;
                goal_q  <= ib.value;
                ramp_q  <= '0;
                whole_q <= '0;
                speed_q <= '0;
              end
              default: ;
            endcase
            if (start_recalc) begin
              state_q <= S_STOP;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_STOP: begin
          if (div_done) begin
            sts_q   <= (dquot > COUNT_MAX) ? COUNT_MAX : dquot;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (stop_now) begin
            whole_q <= '0;
            speed_q <= '0;
            ramp_q  <= '0;
            state_q <= S_OUT;
          end else if (ramp_new == 0) begin
            ramp_q  <= ramp_new;
            ivl_q   <= (first_ivl_q == '0) ? 32'd1 : first_ivl_q;
            cw_q    <= gap_w > 0;
            state_q <= S_SPEED;
          end else begin
            ramp_q  <= ramp_new;
            state_q <= S_IVL;
          end
        end
        S_IVL: begin
          if (div_done) begin
            ivl_q   <= ivl_clamped[31:0];
            state_q <= S_SPEED;
          end
        end
        S_SPEED: begin
          if (div_done) begin
            if (ramp_q != 32'sh7FFF_FFFF) ramp_q <= ramp_q + 32'sd1;
            whole_q <= ivl_q[IvlW-1:FracW];
            speed_q <= cw_q ? SpeedW'(spd_sat) : -SpeedW'(spd_sat);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_q.step_pulse       <= pulse_q;
            out_q.direction        <= cw_q;
            out_q.current_position <= pos_q;
            out_q.step_interval_us <= whole_q;
            out_q.running          <= (speed_q != '0) || (goal_q != pos_q);
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("ready while busy");
  out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> out_valid_q) else $error("result dropped");
  ramp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ramp_q != 32'sh8000_0000) else $error("ramp overflow");
endmodule

// ===== rtl/stp_divider.sv =====
// Shared 64-bit restoring divider, one quotient bit per cycle.
// Depends on stp_pkg.
module stp_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stp_pkg::div_req_t req_i,
  output logic             busy_o,
  output logic [63:0]      quot_o
);
  import stp_pkg::*;

  logic [63:0]  rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic [64:0]  trial;
  logic [64:0]  shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q, quo_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

  busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider not busy after start");
  count_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("divider busy with zero count");
  finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1 && !req_i.start) |=> !busy_q)
    else $error("divider did not finish");
endmodule
